FILE: rtl/core/dch_pkg.sv
// Shared types, widths and constants of the difference coverage tracker.
`timescale 1ns / 1ps

package dch_pkg;

   localparam int TARGET_WIDTH   = 13;
   localparam int SET_SIZE_WIDTH = 9;
   localparam int INDEX_WIDTH    = 8;
   localparam int VALUE_WIDTH    = 16;
   localparam int COUNT_WIDTH    = 8;
   localparam int COVERED_WIDTH  = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 13;

   localparam int MAX_ELEMENTS_DEFAULT   = 256;
   localparam int MAX_DIFFERENCE_DEFAULT = 8192;

   localparam logic [TARGET_WIDTH-1:0]   TARGET_RESET   = 13'd6166;
   localparam logic [SET_SIZE_WIDTH-1:0] SET_SIZE_RESET = 9'd128;
   localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX      = 8'd255;
   localparam logic [COVERED_WIDTH-1:0]  COVERED_MAX    = 13'd8191;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SET_SIZE = 2'd1;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_RECOUNT = 2'd1,
      CMD_MOVE    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic op_valid;
      logic op_up;
      logic clear_start;
   } hist_ctl_type;

endpackage

FILE: rtl/core/dch_elem_mem.sv
// Element store: one write port and one registered read port.
`timescale 1ns / 1ps

module dch_elem_mem #(
   parameter int MAX_ELEMENTS = dch_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [$clog2(MAX_ELEMENTS)-1:0]     waddr,
   input  logic [dch_pkg::VALUE_WIDTH-1:0]     wdata,
   input  logic [$clog2(MAX_ELEMENTS)-1:0]     raddr,
   output logic [dch_pkg::VALUE_WIDTH-1:0]     rdata
);

   logic [dch_pkg::VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
   logic [dch_pkg::VALUE_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/dch_hist.sv
// Difference histogram memory with read-modify-write engine, clearing sweep and covered count.
`timescale 1ns / 1ps

module dch_hist #(
   parameter int MAX_DIFFERENCE = dch_pkg::MAX_DIFFERENCE_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dch_pkg::hist_ctl_type                 ctl,
   input  logic [$clog2(MAX_DIFFERENCE)-1:0]     op_addr,
   output logic                                  clear_busy,
   output logic [dch_pkg::COVERED_WIDTH-1:0]     covered_count
);

   localparam int DW = $clog2(MAX_DIFFERENCE);

   logic [dch_pkg::COUNT_WIDTH-1:0]   mem [MAX_DIFFERENCE];
   logic [dch_pkg::COUNT_WIDTH-1:0]   q_ff;
   logic                              op_valid_ff;
   logic                              op_up_ff;
   logic [DW-1:0]                     op_addr_ff;
   logic                              hit_ff;
   logic [dch_pkg::COUNT_WIDTH-1:0]   fwd_ff;
   logic                              clear_busy_ff;
   logic [DW-1:0]                     clear_addr_ff;
   logic [dch_pkg::COVERED_WIDTH-1:0] covered_ff;

   logic [dch_pkg::COUNT_WIDTH-1:0]   count;
   logic [dch_pkg::COUNT_WIDTH-1:0]   count_in;
   logic                              rise;
   logic                              fall;
   logic                              wr_en;
   logic [DW-1:0]                     wr_addr;
   logic [dch_pkg::COUNT_WIDTH-1:0]   wr_data;

   // A read issued in the cycle of a write to the same bin returns the newly written count.
   always_comb begin
      count = hit_ff ? fwd_ff : q_ff;
      if (op_up_ff) begin
         count_in = (count == dch_pkg::COUNT_MAX) ? count : count + 1'b1;
      end else begin
         count_in = (count == '0) ? count : count - 1'b1;
      end
      rise    = op_valid_ff && op_up_ff && (count == '0);
      fall    = op_valid_ff && !op_up_ff && (count == dch_pkg::COUNT_WIDTH'(1));
      wr_en   = clear_busy_ff || op_valid_ff;
      wr_addr = clear_busy_ff ? clear_addr_ff : op_addr_ff;
      wr_data = clear_busy_ff ? '0 : count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff       <= mem[op_addr];
      op_up_ff   <= ctl.op_up;
      op_addr_ff <= op_addr;
      hit_ff     <= wr_en && (wr_addr == op_addr);
      fwd_ff     <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff   <= 1'b0;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         covered_ff    <= '0;
      end else begin
         op_valid_ff <= ctl.op_valid;
         if (ctl.clear_start) begin
            clear_busy_ff <= 1'b1;
            clear_addr_ff <= '0;
            covered_ff    <= '0;
         end else begin
            if (clear_busy_ff) begin
               if (clear_addr_ff == DW'(MAX_DIFFERENCE - 1)) begin
                  clear_busy_ff <= 1'b0;
               end else begin
                  clear_addr_ff <= clear_addr_ff + 1'b1;
               end
            end
            if (rise && (covered_ff != dch_pkg::COVERED_MAX)) begin
               covered_ff <= covered_ff + 1'b1;
            end else if (fall && (covered_ff != '0)) begin
               covered_ff <= covered_ff - 1'b1;
            end
         end
      end
   end

   assign clear_busy    = clear_busy_ff;
   assign covered_count = covered_ff;

endmodule

FILE: rtl/core/dch_ctrl.sv
// Command sequencer: walks the element store and issues histogram updates.
`timescale 1ns / 1ps

module dch_ctrl #(
   parameter int MAX_ELEMENTS   = dch_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int MAX_DIFFERENCE = dch_pkg::MAX_DIFFERENCE_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [dch_pkg::INDEX_WIDTH-1:0]       req_index,
   input  logic signed [dch_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dch_pkg::COVERED_WIDTH-1:0]     rsp_covered_count,
   output logic                                  rsp_duplicate,
   input  logic [$clog2(MAX_DIFFERENCE)-1:0]     eff_target,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     eff_size,
   output logic                                  elem_we,
   output logic [$clog2(MAX_ELEMENTS)-1:0]       elem_waddr,
   output logic [dch_pkg::VALUE_WIDTH-1:0]       elem_wdata,
   output logic [$clog2(MAX_ELEMENTS)-1:0]       elem_raddr,
   input  logic [dch_pkg::VALUE_WIDTH-1:0]       elem_rdata,
   output dch_pkg::hist_ctl_type                 hist_ctl,
   output logic [$clog2(MAX_DIFFERENCE)-1:0]     hist_addr,
   input  logic                                  clear_busy,
   input  logic [dch_pkg::COVERED_WIDTH-1:0]     covered_count
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int NW = $clog2(MAX_ELEMENTS + 1);
   localparam int DW = $clog2(MAX_DIFFERENCE);
   localparam int VW = dch_pkg::VALUE_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MV_OLD,
      ST_MV_OLDW,
      ST_MV_A,
      ST_MV_B,
      ST_MV_DRAIN,
      ST_RC_CLR,
      ST_RC_I,
      ST_RC_IW,
      ST_RC_J,
      ST_RC_DRAIN,
      ST_DONE
   } state_type;

   state_type                         state_ff;
   dch_pkg::cmd_type                  cmd_ff;
   logic [dch_pkg::INDEX_WIDTH-1:0]   idx_ff;
   logic [VW-1:0]                     val_ff;
   logic [VW-1:0]                     old_ff;
   logic [VW-1:0]                     e_ff;
   logic [VW-1:0]                     ei_ff;
   logic [NW-1:0]                     i_ff;
   logic [NW-1:0]                     j_ff;
   logic                              dup_ff;
   logic                              rsp_valid_ff;
   logic [dch_pkg::COVERED_WIDTH-1:0] rsp_covered_count_ff;
   logic                              rsp_duplicate_ff;

   logic                              idx_wrap;
   logic                              idx_in_set;
   logic                              skip;
   logic                              j_last;
   logic [VW-1:0]                     op_a;
   logic [VW-1:0]                     op_b;
   logic                              op_up;
   logic                              op_en;
   logic signed [VW:0]                diff;
   logic [VW:0]                       mag;
   logic                              in_range;

   always_comb begin
      idx_wrap   = 32'(idx_ff) >= 32'(MAX_ELEMENTS);
      idx_in_set = 32'(idx_ff) < 32'(eff_size);
      skip       = 32'(j_ff) == 32'(idx_ff);
      j_last     = j_ff == (eff_size - NW'(1));

      op_a  = old_ff;
      op_b  = elem_rdata;
      op_up = 1'b0;
      op_en = 1'b0;
      case (state_ff)
         ST_MV_A: begin
            op_a  = old_ff;
            op_b  = elem_rdata;
            op_up = 1'b0;
            op_en = !skip;
         end
         ST_MV_B: begin
            op_a  = val_ff;
            op_b  = e_ff;
            op_up = 1'b1;
            op_en = !skip;
         end
         ST_RC_J: begin
            op_a  = ei_ff;
            op_b  = elem_rdata;
            op_up = 1'b1;
            op_en = 1'b1;
         end
         default: ;
      endcase

      diff     = $signed({op_a[VW-1], op_a}) - $signed({op_b[VW-1], op_b});
      mag      = diff[VW] ? unsigned'(-diff) : unsigned'(diff);
      in_range = (mag != '0) && (32'(mag) <= 32'(eff_target));

      hist_ctl.op_valid    = op_en && in_range;
      hist_ctl.op_up       = op_up;
      hist_ctl.clear_start = (state_ff == ST_DISPATCH) && !idx_wrap
                             && (cmd_ff == dch_pkg::CMD_RECOUNT);
      hist_addr            = DW'(mag);

      case (state_ff)
         ST_MV_OLD: elem_raddr = AW'(idx_ff);
         ST_MV_B:   elem_raddr = AW'(j_ff + NW'(1));
         ST_RC_I:   elem_raddr = AW'(i_ff);
         ST_RC_IW:  elem_raddr = AW'(i_ff + NW'(1));
         ST_RC_J:   elem_raddr = AW'(j_ff + NW'(1));
         default:   elem_raddr = '0;
      endcase

      elem_we    = ((state_ff == ST_DISPATCH) && !idx_wrap && (cmd_ff == dch_pkg::CMD_WRITE))
                   || (state_ff == ST_MV_DRAIN);
      elem_waddr = AW'(idx_ff);
      elem_wdata = val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff   <= dch_pkg::cmd_type'(req_command);
                  idx_ff   <= req_index;
                  val_ff   <= req_value;
                  dup_ff   <= 1'b0;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               if (idx_wrap) begin
                  idx_ff <= idx_ff - dch_pkg::INDEX_WIDTH'(MAX_ELEMENTS);
               end else begin
                  unique case (cmd_ff)
                     dch_pkg::CMD_WRITE:   state_ff <= ST_DONE;
                     dch_pkg::CMD_RECOUNT: state_ff <= ST_RC_CLR;
                     dch_pkg::CMD_MOVE:    state_ff <= idx_in_set ? ST_MV_OLD : ST_DONE;
                     default:              state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_MV_OLD: begin
               state_ff <= ST_MV_OLDW;
            end
            ST_MV_OLDW: begin
               old_ff   <= elem_rdata;
               j_ff     <= '0;
               state_ff <= ST_MV_A;
            end
            ST_MV_A: begin
               e_ff <= elem_rdata;
               if (!skip && (elem_rdata == val_ff)) begin
                  dup_ff <= 1'b1;
               end
               state_ff <= ST_MV_B;
            end
            ST_MV_B: begin
               if (j_last) begin
                  state_ff <= ST_MV_DRAIN;
               end else begin
                  j_ff     <= j_ff + NW'(1);
                  state_ff <= ST_MV_A;
               end
            end
            ST_MV_DRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_RC_CLR: begin
               if (!clear_busy) begin
                  i_ff     <= '0;
                  state_ff <= (32'(eff_size) >= 32'd2) ? ST_RC_I : ST_DONE;
               end
            end
            ST_RC_I: begin
               state_ff <= ST_RC_IW;
            end
            ST_RC_IW: begin
               ei_ff    <= elem_rdata;
               j_ff     <= i_ff + NW'(1);
               state_ff <= ST_RC_J;
            end
            ST_RC_J: begin
               if (j_last) begin
                  i_ff     <= i_ff + NW'(1);
                  state_ff <= (32'(i_ff) + 32'd2 >= 32'(eff_size)) ? ST_RC_DRAIN : ST_RC_I;
               end else begin
                  j_ff <= j_ff + NW'(1);
               end
            end
            ST_RC_DRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_covered_count_ff <= covered_count;
                  rsp_duplicate_ff     <= dup_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE) && !clear_busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_covered_count = rsp_covered_count_ff;
   assign rsp_duplicate     = rsp_duplicate_ff;

endmodule

FILE: rtl/core/difference_coverage_tracker.sv
// A write stores the value; an unused command or a move outside the set changes nothing. A move
// makes two histogram updates per element, and a recount clears the histogram and then adds
// every pair of the set (only the clear for fewer than two elements). An index at or above
// MAX_ELEMENTS is first folded by repeated subtraction of MAX_ELEMENTS.
// One request is in work at a time; a new one is taken while a response waits. Reset is
// synchronous and clears the histogram, with no request accepted until the clear is done.
`timescale 1ns / 1ps

module difference_coverage_tracker #(
   parameter int MAX_ELEMENTS   = dch_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int MAX_DIFFERENCE = dch_pkg::MAX_DIFFERENCE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_command,
   input  logic [dch_pkg::INDEX_WIDTH-1:0]        req_index,
   input  logic signed [dch_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dch_pkg::COVERED_WIDTH-1:0]      rsp_covered_count,
   output logic                                   rsp_duplicate,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dch_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dch_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int NW = $clog2(MAX_ELEMENTS + 1);
   localparam int DW = $clog2(MAX_DIFFERENCE);

   logic [dch_pkg::TARGET_WIDTH-1:0]   target_ff;
   logic [dch_pkg::SET_SIZE_WIDTH-1:0] set_size_ff;
   logic [DW-1:0]                      eff_target;
   logic [NW-1:0]                      eff_size;

   logic                               elem_we;
   logic [AW-1:0]                      elem_waddr;
   logic [dch_pkg::VALUE_WIDTH-1:0]    elem_wdata;
   logic [AW-1:0]                      elem_raddr;
   logic [dch_pkg::VALUE_WIDTH-1:0]    elem_rdata;
   dch_pkg::hist_ctl_type              hist_ctl;
   logic [DW-1:0]                      hist_addr;
   logic                               clear_busy;
   logic [dch_pkg::COVERED_WIDTH-1:0]  covered_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= dch_pkg::TARGET_RESET;
         set_size_ff <= dch_pkg::SET_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dch_pkg::CSR_TARGET:   target_ff   <= csr_data;
            dch_pkg::CSR_SET_SIZE: set_size_ff <= csr_data[dch_pkg::SET_SIZE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(target_ff) >= 32'(MAX_DIFFERENCE)) begin
         eff_target = DW'(MAX_DIFFERENCE - 1);
      end else begin
         eff_target = DW'(target_ff);
      end
      if (32'(set_size_ff) > 32'(MAX_ELEMENTS)) begin
         eff_size = NW'(MAX_ELEMENTS);
      end else begin
         eff_size = NW'(set_size_ff);
      end
   end

   assign csr_ready = 1'b1;

   dch_elem_mem #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_elem (
      .clock (clock),
      .we    (elem_we),
      .waddr (elem_waddr),
      .wdata (elem_wdata),
      .raddr (elem_raddr),
      .rdata (elem_rdata)
   );

   dch_hist #(
      .MAX_DIFFERENCE (MAX_DIFFERENCE)
   ) u_hist (
      .clock         (clock),
      .reset         (reset),
      .ctl           (hist_ctl),
      .op_addr       (hist_addr),
      .clear_busy    (clear_busy),
      .covered_count (covered_count)
   );

   dch_ctrl #(
      .MAX_ELEMENTS   (MAX_ELEMENTS),
      .MAX_DIFFERENCE (MAX_DIFFERENCE)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_index         (req_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_covered_count (rsp_covered_count),
      .rsp_duplicate     (rsp_duplicate),
      .eff_target        (eff_target),
      .eff_size          (eff_size),
      .elem_we           (elem_we),
      .elem_waddr        (elem_waddr),
      .elem_wdata        (elem_wdata),
      .elem_raddr        (elem_raddr),
      .elem_rdata        (elem_rdata),
      .hist_ctl          (hist_ctl),
      .hist_addr         (hist_addr),
      .clear_busy        (clear_busy),
      .covered_count     (covered_count)
   );

endmodule

FILE: dv/difference_coverage_tracker_tb.sv
// Self-checking testbench for the difference coverage tracker with a built-in histogram predictor.
`timescale 1ns / 1ps

module difference_coverage_tracker_tb;

   localparam int MAX_SET     = dch_pkg::MAX_ELEMENTS_DEFAULT;
   localparam int MAX_DIFF    = dch_pkg::MAX_DIFFERENCE_DEFAULT;
   localparam int QUIET_LIMIT = 200000;
   localparam int ITEM_GOAL   = 1100;
   localparam int CALM_FROM   = 950;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [dch_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [dch_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [1:0]                             command;
      logic [dch_pkg::INDEX_WIDTH-1:0]        index;
      logic signed [dch_pkg::VALUE_WIDTH-1:0] value;
   } tracker_request_type;

   typedef struct packed {
      logic [dch_pkg::COVERED_WIDTH-1:0] covered;
      logic                              duplicate;
   } coverage_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [dch_pkg::INDEX_WIDTH-1:0] req_index = '0;
   logic signed [dch_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [dch_pkg::COVERED_WIDTH-1:0] rsp_covered_count;
   logic rsp_duplicate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dch_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [dch_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   difference_coverage_tracker dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_covered_count(rsp_covered_count),
      .rsp_duplicate(rsp_duplicate),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state.
   int                                 elem_value [MAX_SET];
   bit [dch_pkg::COUNT_WIDTH-1:0]      diff_count [MAX_DIFF];
   bit [dch_pkg::COVERED_WIDTH-1:0]    covered_now = '0;
   logic [dch_pkg::TARGET_WIDTH-1:0]   target_reg = dch_pkg::TARGET_RESET;
   logic [dch_pkg::SET_SIZE_WIDTH-1:0] size_reg = dch_pkg::SET_SIZE_RESET;

   // Stimulus planning state.
   logic signed [dch_pkg::VALUE_WIDTH-1:0] plan_value [MAX_SET];
   bit   plan_written [MAX_SET];
   int   plan_size = dch_pkg::SET_SIZE_RESET;
   int   gen_mode = 2;
   int   cluster_base = 0;
   int   cluster_step = 1;

   tracker_request_type request_backlog [$];
   coverage_result_type coverage_due [$];
   tracker_request_type req_now;
   coverage_result_type rsp_want;

   bit idle_on = 1'b1;
   int req_gap = 0;
   int rsp_stall = 0;
   int quiet_cycles = 0;
   int outstanding = 0;
   int total_pushed = 0;
   int mismatches = 0;
   int responses_checked = 0;
   int recount_total = 0;
   int move_total = 0;
   int dup_total = 0;
   int setting_total = 0;

   function automatic void shift_difference(input int a, input int b, input bit up);
      int d;
      int span;
      d = a - b;
      if (d < 0) d = -d;
      span = (target_reg >= MAX_DIFF) ? MAX_DIFF - 1 : int'(target_reg);
      if (d == 0 || d > span) return;
      if (up) begin
         if (diff_count[d] == 0 && covered_now < dch_pkg::COVERED_MAX) covered_now++;
         if (diff_count[d] < dch_pkg::COUNT_MAX) diff_count[d]++;
      end else begin
         if (diff_count[d] == 0) return;
         diff_count[d]--;
         if (diff_count[d] == 0 && covered_now > 0) covered_now--;
      end
   endfunction

   function automatic coverage_result_type coverage_after(input tracker_request_type r);
      coverage_result_type res;
      int n;
      int old_value;
      int i;
      int j;
      n = (size_reg > MAX_SET) ? MAX_SET : int'(size_reg);
      res.duplicate = 1'b0;
      case (r.command)
         dch_pkg::CMD_WRITE: elem_value[r.index] = r.value;
         dch_pkg::CMD_RECOUNT: begin
            recount_total++;
            foreach (diff_count[k]) diff_count[k] = '0;
            covered_now = '0;
            for (i = 0; i < n; i++)
               for (j = i + 1; j < n; j++)
                  shift_difference(elem_value[i], elem_value[j], 1'b1);
         end
         dch_pkg::CMD_MOVE: begin
            if (r.index < n) begin
               move_total++;
               old_value = elem_value[r.index];
               for (j = 0; j < n; j++) begin
                  if (j != r.index) begin
                     if (elem_value[j] == r.value) res.duplicate = 1'b1;
                     shift_difference(old_value, elem_value[j], 1'b0);
                     shift_difference(r.value, elem_value[j], 1'b1);
                  end
               end
               elem_value[r.index] = r.value;
            end
         end
         default: ;
      endcase
      res.covered = covered_now;
      if (res.duplicate) dup_total++;
      return res;
   endfunction

   function automatic logic signed [dch_pkg::VALUE_WIDTH-1:0] pick_value();
      int v;
      case (gen_mode)
         0: v = $urandom_range(0, 65535);
         1: v = cluster_base + cluster_step * int'($urandom_range(0, 2));
         default: v = cluster_base + int'($urandom_range(0, 63));
      endcase
      return v[15:0];
   endfunction

   task automatic queue_request(input logic [1:0] cmd,
                                input logic [dch_pkg::INDEX_WIDTH-1:0] idx,
                                input logic signed [dch_pkg::VALUE_WIDTH-1:0] val);
      tracker_request_type r;
      r.command = cmd;
      r.index = idx;
      r.value = val;
      request_backlog.push_back(r);
      outstanding++;
      total_pushed++;
      if (cmd == dch_pkg::CMD_WRITE) begin
         plan_value[idx] = val;
         plan_written[idx] = 1'b1;
      end else if (cmd == dch_pkg::CMD_MOVE && idx < plan_size) begin
         plan_value[idx] = val;
      end
   endtask

   task automatic fill_missing();
      int i;
      for (i = 0; i < plan_size; i++)
         if (!plan_written[i]) queue_request(dch_pkg::CMD_WRITE, i[7:0], pick_value());
   endtask

   task automatic rewrite_set();
      int i;
      for (i = 0; i < plan_size; i++) queue_request(dch_pkg::CMD_WRITE, i[7:0], pick_value());
   endtask

   task automatic wait_idle();
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [dch_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [dch_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         dch_pkg::CSR_TARGET:   target_reg = data[dch_pkg::TARGET_WIDTH-1:0];
         dch_pkg::CSR_SET_SIZE: size_reg = data[dch_pkg::SET_SIZE_WIDTH-1:0];
         default: ;
      endcase
      setting_total++;
   endtask

   task automatic set_registers(input logic [dch_pkg::CSR_DATA_WIDTH-1:0] t,
                                input logic [dch_pkg::CSR_DATA_WIDTH-1:0] s);
      wait_idle();
      csr_write(dch_pkg::CSR_TARGET, t);
      csr_write(dch_pkg::CSR_SET_SIZE, s);
      plan_size = (s[8:0] > MAX_SET) ? MAX_SET : int'(s[8:0]);
   endtask

   task automatic random_request();
      int pick;
      int slot;
      pick = $urandom_range(0, 99);
      if (pick < 55 && plan_size > 0) begin
         slot = $urandom_range(0, plan_size - 1);
         if ($urandom_range(0, 5) == 0)
            queue_request(dch_pkg::CMD_MOVE, slot[7:0],
                          plan_value[$urandom_range(0, plan_size - 1)]);
         else
            queue_request(dch_pkg::CMD_MOVE, slot[7:0], pick_value());
      end else if (pick < 62) begin
         queue_request(dch_pkg::CMD_MOVE, 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)));
      end else if (pick < 85) begin
         if (plan_size > 0 && $urandom_range(0, 1) == 0) slot = $urandom_range(0, plan_size - 1);
         else slot = $urandom_range(0, 255);
         queue_request(dch_pkg::CMD_WRITE, slot[7:0], pick_value());
      end else if (pick < 89) begin
         queue_request(dch_pkg::CMD_RECOUNT, 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)));
      end else if (pick < 94) begin
         queue_request(CMD_SPARE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end else begin
         queue_request(dch_pkg::CMD_MOVE, 8'($urandom_range(0, 255)), pick_value());
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            coverage_due.push_back(coverage_after(req_now));
            if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 15);
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               req_now = request_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= req_now.command;
               req_index <= req_now.index;
               req_value <= req_now.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (coverage_due.size() == 0) begin
               $display("%0t: response with no request pending, covered_count %0d duplicate %0d",
                        $time, rsp_covered_count, rsp_duplicate);
               mismatches++;
            end else begin
               rsp_want = coverage_due.pop_front();
               if (rsp_covered_count !== rsp_want.covered) begin
                  $display("%0t: covered_count expected %0d, actual %0d",
                           $time, rsp_want.covered, rsp_covered_count);
                  mismatches++;
               end
               if (rsp_duplicate !== rsp_want.duplicate) begin
                  $display("%0t: duplicate expected %0d, actual %0d",
                           $time, rsp_want.duplicate, rsp_duplicate);
                  mismatches++;
               end
               responses_checked++;
               outstanding--;
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 15);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[difference_coverage_tracker] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int t;
      int s;
      int pick;
      int i;
      int phases;
      phases = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: field extremes, the unused command and a move outside the set.
      queue_request(dch_pkg::CMD_WRITE, 8'd0, 16'sh8000);
      queue_request(dch_pkg::CMD_WRITE, 8'd255, 16'sh7FFF);
      queue_request(dch_pkg::CMD_WRITE, 8'h55, 16'sh5555);
      queue_request(dch_pkg::CMD_WRITE, 8'hAA, 16'shAAAA);
      queue_request(CMD_SPARE, 8'hFF, 16'shFFFF);
      queue_request(dch_pkg::CMD_MOVE, 8'd200, 16'sd5);
      gen_mode = 2;
      cluster_base = 1000;
      fill_missing();
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
      queue_request(dch_pkg::CMD_MOVE, 8'd0, 16'sh8000);
      queue_request(dch_pkg::CMD_MOVE, 8'd1, 16'sh7FFF);
      queue_request(dch_pkg::CMD_MOVE, 8'd2, plan_value[3]);
      queue_request(dch_pkg::CMD_MOVE, 8'd4, plan_value[4]);
      queue_request(dch_pkg::CMD_MOVE, 8'd127, pick_value());
      queue_request(dch_pkg::CMD_MOVE, 8'd128, pick_value());
      queue_request(dch_pkg::CMD_RECOUNT, 8'hFF, 16'shFFFF);

      // A target of zero counts nothing.
      set_registers(13'd0, 13'd2);
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
      queue_request(dch_pkg::CMD_MOVE, 8'd0, 16'sd77);
      queue_request(dch_pkg::CMD_MOVE, 8'd1, plan_value[0]);

      // Largest target and an oversized set, which acts as a full set.
      set_registers(13'h1FFF, 13'h1FFF);
      gen_mode = 0;
      fill_missing();
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
      repeat (8) random_request();

      // Sets too small to form pairs.
      set_registers(13'd1, 13'd0);
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
      queue_request(dch_pkg::CMD_MOVE, 8'd0, 16'sd9);
      set_registers(13'd1, 13'd1);
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
      queue_request(dch_pkg::CMD_MOVE, 8'd0, 16'sd10);
      wait_idle();
      csr_write(CSR_SPARE_LO, 13'($urandom_range(0, 8191)));
      csr_write(CSR_SPARE_HI, 13'($urandom_range(0, 8191)));

      // Two value clusters push one difference past the counter ceiling.
      set_registers(13'd100, 13'd48);
      for (i = 0; i < 48; i++)
         queue_request(dch_pkg::CMD_WRITE, i[7:0], (i % 2 != 0) ? 16'sd47 : 16'sd40);
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
      for (i = 0; i < 6; i++)
         queue_request(dch_pkg::CMD_MOVE, i[7:0], (i % 2 != 0) ? 16'sd40 : 16'sd47);

      // A new target keeps the old histogram until the next recount.
      set_registers(13'd3, 13'd48);
      gen_mode = 2;
      cluster_base = 40;
      repeat (6) queue_request(dch_pkg::CMD_MOVE, 8'($urandom_range(0, 47)), pick_value());
      queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);

      while (total_pushed < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) t = 0;
         else if (pick < 20) t = 8191;
         else if (pick < 40) t = $urandom_range(1, 64);
         else t = $urandom_range(1, 8191);
         pick = $urandom_range(0, 99);
         if (pick < 68) s = $urandom_range(2, 20);
         else if (pick < 90) s = $urandom_range(21, 64);
         else if (pick < 96) s = $urandom_range(0, 1);
         else s = $urandom_range(256, 511);
         s = s + 512 * int'($urandom_range(0, 15));
         set_registers(t[12:0], s[12:0]);
         if ($urandom_range(0, 9) == 0)
            csr_write($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                      13'($urandom_range(0, 8191)));
         idle_on = (total_pushed < CALM_FROM) && ($urandom_range(0, 3) != 0);
         gen_mode = $urandom_range(0, 2);
         cluster_base = int'($urandom_range(0, 60000)) - 30000;
         cluster_step = $urandom_range(1, 300);
         if ($urandom_range(0, 9) < 7) rewrite_set();
         else fill_missing();
         if ($urandom_range(0, 9) < 7) queue_request(dch_pkg::CMD_RECOUNT, 8'd0, 16'sd0);
         repeat ($urandom_range(15, 40)) random_request();
         phases++;
      end

      wait_idle();
      repeat (600) @(posedge clock);
      $display("Checked %0d responses over %0d random phases and %0d register writes.",
               responses_checked, phases, setting_total);
      $display("The predictor saw %0d recounts, %0d moves inside the set, %0d duplicate flags.",
               recount_total, move_total, dup_total);
      if (mismatches == 0 && coverage_due.size() == 0) begin
         $display("[difference_coverage_tracker] OK");
      end else begin
         $display("[difference_coverage_tracker] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/dch_pkg.sv
rtl/core/dch_elem_mem.sv
rtl/core/dch_hist.sv
rtl/core/dch_ctrl.sv
rtl/core/difference_coverage_tracker.sv
dv/difference_coverage_tracker_tb.sv
